>>> design/sump_pump_fault_classifier_top_defines.svh
// Assertion macros for the sump pump fault classifier.
`ifndef SUMP_PUMP_FAULT_CLASSIFIER_TOP_DEFINES_SVH
`define SUMP_PUMP_FAULT_CLASSIFIER_TOP_DEFINES_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define SPFC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on the rising clock edge outside reset.
`define SPFC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/spfc_pkg.sv
// Types and constants shared by the sump pump fault classifier.
package spfc_pkg;

    typedef struct packed {
        logic [14:0]        pump_current_ma;
        logic [13:0]        vibration_mg;
        logic [11:0]        water_level_mm;
        logic [11:0]        rebound_mm;
        logic signed [15:0] drawdown_rate;
        logic signed [15:0] rise_rate;
        logic [9:0]         humidity_tenths;
        logic [12:0]        battery_mv;
        logic               leak_flag;
        logic               power_fail_flag;
        logic               float_flag;
    } frame_t;

    typedef struct packed {
        logic [2:0] condition;
        logic [9:0] flood_risk;
        logic [9:0] cycle_health;
        logic [9:0] severity;
    } result_t;

    localparam int CFG_DATA_W = 15;
    localparam int CFG_IDX_W  = 3;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_WATER      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DRY_PIT         = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STRONG_REBOUND  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SHALLOW_REBOUND = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HUMIDITY_ALERT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_RUN_CURRENT     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_RUN_VIBRATION   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_BATTERY     = 3'd7;

    // Condition codes.
    localparam logic [2:0] COND_HEALTHY       = 3'd0;
    localparam logic [2:0] COND_NO_START      = 3'd1;
    localparam logic [2:0] COND_BACKFLOW      = 3'd2;
    localparam logic [2:0] COND_SHORT_CYCLING = 3'd3;
    localparam logic [2:0] COND_DRY_RUN       = 3'd4;
    localparam logic [2:0] COND_SLOW_PUMP     = 3'd5;
    localparam logic [2:0] COND_LEAK          = 3'd6;
    localparam logic [2:0] COND_HUMIDITY      = 3'd7;

    // Scores in tenths of a point.
    localparam logic [9:0] SCORE_MAX            = 10'd1000;
    localparam logic [9:0] FAULT_NO_START       = 10'd960;
    localparam logic [9:0] FAULT_DRY_RUN        = 10'd820;
    localparam logic [9:0] FAULT_BACKFLOW       = 10'd780;
    localparam logic [9:0] FAULT_SHORT_CYCLING  = 10'd700;
    localparam logic [9:0] FAULT_SLOW_PUMP      = 10'd740;
    localparam logic [9:0] FAULT_HUMIDITY       = 10'd440;
    localparam logic [9:0] FAULT_HEALTHY_MAX    = 10'd400;
    localparam logic [9:0] POWER_FAIL_BONUS     = 10'd120;

    localparam logic [9:0] PEN_STOPPED_FLOAT    = 10'd750;
    localparam logic [9:0] PEN_SLOW_DRAW        = 10'd350;
    localparam logic [9:0] PEN_REBOUND          = 10'd250;
    localparam logic [9:0] PEN_DRY_RUNNING      = 10'd450;

    // Level terms of the flood risk and the slow pump test.
    localparam logic [11:0] FLOOD_BASE_MM       = 12'd280;
    localparam logic [11:0] FLOOD_SAT_SPAN_MM   = 12'd300;
    localparam logic [11:0] SLOW_PUMP_LEVEL_MM  = 12'd420;
    // x/3 == (x * 43691) >> 17 exactly for x below 2^16.
    localparam logic [15:0] RECIP_THREE         = 16'd43691;
    localparam int          RECIP_SHIFT         = 17;

    // Rate limits in tenths of mm per minute.
    localparam logic signed [15:0] SLOW_DRAW_LIMIT = -16'sd400;
    localparam logic signed [15:0] DRY_DRAW_LIMIT  = -16'sd120;
    localparam logic signed [15:0] RISE_LIMIT      = 16'sd20;

    // Register reset values.
    localparam logic [11:0] RST_HIGH_WATER      = 12'd500;
    localparam logic [11:0] RST_DRY_PIT         = 12'd140;
    localparam logic [11:0] RST_STRONG_REBOUND  = 12'd70;
    localparam logic [11:0] RST_SHALLOW_REBOUND = 12'd40;
    localparam logic [9:0]  RST_HUMIDITY_ALERT  = 10'd820;
    localparam logic [14:0] RST_RUN_CURRENT     = 15'd1000;
    localparam logic [13:0] RST_RUN_VIBRATION   = 14'd80;
    localparam logic [12:0] RST_LOW_BATTERY     = 13'd3850;

endpackage

>>> design/sump_pump_fault_classifier_top.sv
// Sump pump fault classifier: one sensor frame in, one classified result out.
// Each frame is captured in an input register, classified by comparators and
// one constant multiplication, and held in the result register, where done
// marks it for exactly one cycle. A new frame is taken in every cycle, so
// busy stays low; the receiver must take each result in the cycle that done
// is high.
`include "sump_pump_fault_classifier_top_defines.svh"

module sump_pump_fault_classifier_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  spfc_pkg::frame_t                    frame,
    output logic                                done,
    output spfc_pkg::result_t                   result,
    input  logic                                cfg_we,
    input  logic [spfc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [spfc_pkg::CFG_DATA_W-1:0]     cfg_data
);

    // Configuration registers.
    logic [11:0] high_water_reg;
    logic [11:0] dry_pit_reg;
    logic [11:0] strong_rebound_reg;
    logic [11:0] shallow_rebound_reg;
    logic [9:0]  humidity_alert_reg;
    logic [14:0] run_current_reg;
    logic [13:0] run_vibration_reg;
    logic [12:0] low_battery_reg;

    logic              in_valid_reg;
    spfc_pkg::frame_t  in_frame_reg;
    logic              done_reg;
    spfc_pkg::result_t result_reg;
    spfc_pkg::result_t result_next;

    logic        running;
    logic        level_high;
    logic        rebound_big;
    logic        shallow;
    logic        slow_draw;
    logic        dry;
    logic        humid;
    logic [11:0] level_diff;
    logic [11:0] level_x10;
    logic [27:0] third_prod;
    logic [9:0]  flood_base;
    logic [9:0]  flood_leak;
    logic [10:0] flood_sum;
    logic [9:0]  flood;
    logic [11:0] penalty;
    logic [9:0]  health;
    logic [9:0]  health_loss;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            high_water_reg      <= spfc_pkg::RST_HIGH_WATER;
            dry_pit_reg         <= spfc_pkg::RST_DRY_PIT;
            strong_rebound_reg  <= spfc_pkg::RST_STRONG_REBOUND;
            shallow_rebound_reg <= spfc_pkg::RST_SHALLOW_REBOUND;
            humidity_alert_reg  <= spfc_pkg::RST_HUMIDITY_ALERT;
            run_current_reg     <= spfc_pkg::RST_RUN_CURRENT;
            run_vibration_reg   <= spfc_pkg::RST_RUN_VIBRATION;
            low_battery_reg     <= spfc_pkg::RST_LOW_BATTERY;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                spfc_pkg::REG_HIGH_WATER:      high_water_reg      <= cfg_data[11:0];
                spfc_pkg::REG_DRY_PIT:         dry_pit_reg         <= cfg_data[11:0];
                spfc_pkg::REG_STRONG_REBOUND:  strong_rebound_reg  <= cfg_data[11:0];
                spfc_pkg::REG_SHALLOW_REBOUND: shallow_rebound_reg <= cfg_data[11:0];
                spfc_pkg::REG_HUMIDITY_ALERT:  humidity_alert_reg  <= cfg_data[9:0];
                spfc_pkg::REG_RUN_CURRENT:     run_current_reg     <= cfg_data[14:0];
                spfc_pkg::REG_RUN_VIBRATION:   run_vibration_reg   <= cfg_data[13:0];
                spfc_pkg::REG_LOW_BATTERY:     low_battery_reg     <= cfg_data[12:0];
                default: ;
            endcase
        end
    end

    // Input register: every start is a transfer since busy never rises.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            in_frame_reg <= frame;
        end
    end

    always_comb
    begin
        running     = (in_frame_reg.pump_current_ma > run_current_reg)
                   || (in_frame_reg.vibration_mg > run_vibration_reg);
        level_high  = in_frame_reg.water_level_mm > high_water_reg;
        rebound_big = in_frame_reg.rebound_mm > strong_rebound_reg;
        shallow     = in_frame_reg.rebound_mm > shallow_rebound_reg;
        slow_draw   = in_frame_reg.drawdown_rate > spfc_pkg::SLOW_DRAW_LIMIT;
        dry         = in_frame_reg.water_level_mm < dry_pit_reg;
        humid       = in_frame_reg.humidity_tenths > humidity_alert_reg;

        // Flood risk saturates once the level is 300 mm above its base, so
        // only a short span goes through the divide by three.
        level_diff = in_frame_reg.water_level_mm - spfc_pkg::FLOOD_BASE_MM;
        level_x10  = {level_diff[8:0], 3'b000} + {2'b00, level_diff[8:0], 1'b0};
        third_prod = 28'(level_x10) * 28'(spfc_pkg::RECIP_THREE);
        if (in_frame_reg.water_level_mm <= spfc_pkg::FLOOD_BASE_MM)
        begin
            flood_base = 10'd0;
        end
        else if (level_diff >= spfc_pkg::FLOOD_SAT_SPAN_MM)
        begin
            flood_base = spfc_pkg::SCORE_MAX;
        end
        else
        begin
            flood_base = third_prod[spfc_pkg::RECIP_SHIFT +: 10];
        end
        flood_leak = in_frame_reg.leak_flag ? spfc_pkg::SCORE_MAX : flood_base;
        flood_sum  = {1'b0, flood_leak} + {1'b0, spfc_pkg::POWER_FAIL_BONUS};
        if (in_frame_reg.power_fail_flag && (in_frame_reg.battery_mv < low_battery_reg))
        begin
            flood = (flood_sum > {1'b0, spfc_pkg::SCORE_MAX}) ? spfc_pkg::SCORE_MAX
                                                               : flood_sum[9:0];
        end
        else
        begin
            flood = flood_leak;
        end

        penalty = 12'd0;
        if (in_frame_reg.float_flag && !running)
        begin
            penalty = penalty + {2'b00, spfc_pkg::PEN_STOPPED_FLOAT};
        end
        if (slow_draw)
        begin
            penalty = penalty + {2'b00, spfc_pkg::PEN_SLOW_DRAW};
        end
        if (rebound_big || shallow)
        begin
            penalty = penalty + {2'b00, spfc_pkg::PEN_REBOUND};
        end
        if (dry && running)
        begin
            penalty = penalty + {2'b00, spfc_pkg::PEN_DRY_RUNNING};
        end
        health      = (penalty >= {2'b00, spfc_pkg::SCORE_MAX}) ? 10'd0
                    : (spfc_pkg::SCORE_MAX - penalty[9:0]);
        health_loss = spfc_pkg::SCORE_MAX - health;

        result_next.flood_risk   = flood;
        result_next.cycle_health = health;
        if (in_frame_reg.leak_flag)
        begin
            result_next.condition = spfc_pkg::COND_LEAK;
            result_next.severity  = spfc_pkg::SCORE_MAX;
        end
        else if (in_frame_reg.float_flag && !running && level_high)
        begin
            result_next.condition = spfc_pkg::COND_NO_START;
            result_next.severity  = spfc_pkg::FAULT_NO_START;
        end
        else if (dry && running && (in_frame_reg.drawdown_rate > spfc_pkg::DRY_DRAW_LIMIT))
        begin
            result_next.condition = spfc_pkg::COND_DRY_RUN;
            result_next.severity  = spfc_pkg::FAULT_DRY_RUN;
        end
        else if (rebound_big)
        begin
            result_next.condition = spfc_pkg::COND_BACKFLOW;
            result_next.severity  = spfc_pkg::FAULT_BACKFLOW;
        end
        else if (shallow && in_frame_reg.float_flag)
        begin
            result_next.condition = spfc_pkg::COND_SHORT_CYCLING;
            result_next.severity  = spfc_pkg::FAULT_SHORT_CYCLING;
        end
        else if (running && slow_draw
                 && (in_frame_reg.water_level_mm > spfc_pkg::SLOW_PUMP_LEVEL_MM))
        begin
            result_next.condition = spfc_pkg::COND_SLOW_PUMP;
            result_next.severity  = spfc_pkg::FAULT_SLOW_PUMP;
        end
        else if (humid && !running && (in_frame_reg.rise_rate < spfc_pkg::RISE_LIMIT))
        begin
            result_next.condition = spfc_pkg::COND_HUMIDITY;
            result_next.severity  = spfc_pkg::FAULT_HUMIDITY;
        end
        else
        begin
            result_next.condition = spfc_pkg::COND_HEALTHY;
            result_next.severity  = (health_loss > spfc_pkg::FAULT_HEALTHY_MAX)
                                  ? spfc_pkg::FAULT_HEALTHY_MAX : health_loss;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid_reg)
        begin
            result_reg <= result_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    `SPFC_ASSERT_NEXT(a_start_to_done, clk, rst_n, start && !busy, ##1 done,
        "accepted frame gave no result two cycles later")
    `SPFC_ASSERT_NOW(a_leak_scores, clk, rst_n,
        done && (result.condition == spfc_pkg::COND_LEAK),
        (result.severity == spfc_pkg::SCORE_MAX) && (result.flood_risk == spfc_pkg::SCORE_MAX),
        "leak result without full scores")
    `SPFC_ASSERT_NOW(a_healthy_fault, clk, rst_n,
        done && (result.condition == spfc_pkg::COND_HEALTHY),
        result.severity <= spfc_pkg::FAULT_HEALTHY_MAX,
        "healthy fault score above its cap")
    `SPFC_ASSERT_NOW(a_score_range, clk, rst_n, done,
        (result.flood_risk <= spfc_pkg::SCORE_MAX) && (result.cycle_health <= spfc_pkg::SCORE_MAX),
        "score out of range")

endmodule

>>> dv/sump_pump_fault_classifier_top_test.sv
// Self-checking testbench for the sump pump fault classifier: directed and random frames.
module sump_pump_fault_classifier_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned WATCHDOG_LIMIT = 4000;
    localparam int unsigned RANDOM_PER_PHASE = 255;

    logic clk;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    spfc_pkg::frame_t frame = '0;
    logic done;
    spfc_pkg::result_t result;
    logic cfg_we = 1'b0;
    logic [spfc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [spfc_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    // Local copy of the threshold registers, at their hardware widths.
    logic [11:0] lim_high_water = 12'd500;
    logic [11:0] lim_dry_pit = 12'd140;
    logic [11:0] lim_strong_rebound = 12'd70;
    logic [11:0] lim_shallow_rebound = 12'd40;
    logic [9:0] lim_humidity = 10'd820;
    logic [14:0] lim_run_current = 15'd1000;
    logic [13:0] lim_run_vibration = 14'd80;
    logic [12:0] lim_low_battery = 13'd3850;

    spfc_pkg::frame_t frames_pending[$];
    spfc_pkg::result_t results_due[$];
    int fails = 0;
    int unsigned quiet_cycles = 0;
    int unsigned gap_left = 0;
    int unsigned run_left = 0;
    bit steady = 1'b0;

    sump_pump_fault_classifier_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .frame     (frame),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic spfc_pkg::result_t classify_frame(spfc_pkg::frame_t f);
        logic running;
        logic rebound_big;
        logic shallow;
        logic slow_draw;
        logic dry;
        logic humid;
        int flood;
        int health;
        int fault;
        spfc_pkg::result_t r;
        running = (f.pump_current_ma > lim_run_current) || (f.vibration_mg > lim_run_vibration);
        rebound_big = f.rebound_mm > lim_strong_rebound;
        shallow = f.rebound_mm > lim_shallow_rebound;
        slow_draw = int'(f.drawdown_rate) > -400;
        dry = f.water_level_mm < lim_dry_pit;
        humid = f.humidity_tenths > lim_humidity;

        flood = 0;
        if (f.water_level_mm > 12'd280)
            flood = (int'(f.water_level_mm) - 280) * 10 / 3;
        if (flood > 1000)
            flood = 1000;
        if (f.leak_flag)
            flood = 1000;
        if (f.power_fail_flag && (f.battery_mv < lim_low_battery))
            flood = (flood + 120 > 1000) ? 1000 : flood + 120;

        health = 1000;
        if (f.float_flag && !running)
            health -= 750;
        if (slow_draw)
            health -= 350;
        if (rebound_big || shallow)
            health -= 250;
        if (dry && running)
            health -= 450;
        if (health < 0)
            health = 0;

        if (f.leak_flag)
        begin
            r.condition = spfc_pkg::COND_LEAK;
            fault = 1000;
        end
        else if (f.float_flag && !running && (f.water_level_mm > lim_high_water))
        begin
            r.condition = spfc_pkg::COND_NO_START;
            fault = 960;
        end
        else if (dry && running && (int'(f.drawdown_rate) > -120))
        begin
            r.condition = spfc_pkg::COND_DRY_RUN;
            fault = 820;
        end
        else if (rebound_big)
        begin
            r.condition = spfc_pkg::COND_BACKFLOW;
            fault = 780;
        end
        else if (shallow && f.float_flag)
        begin
            r.condition = spfc_pkg::COND_SHORT_CYCLING;
            fault = 700;
        end
        else if (running && slow_draw && (f.water_level_mm > 12'd420))
        begin
            r.condition = spfc_pkg::COND_SLOW_PUMP;
            fault = 740;
        end
        else if (humid && !running && (int'(f.rise_rate) < 20))
        begin
            r.condition = spfc_pkg::COND_HUMIDITY;
            fault = 440;
        end
        else
        begin
            r.condition = spfc_pkg::COND_HEALTHY;
            fault = (1000 - health > 400) ? 400 : 1000 - health;
        end

        r.flood_risk = 10'(flood);
        r.cycle_health = 10'(health);
        r.severity = 10'(fault);
        return r;
    endfunction

    // A quiet frame under the reset thresholds: pump stopped, level moderate, healthy.
    function automatic spfc_pkg::frame_t base_frame();
        spfc_pkg::frame_t f;
        f = '0;
        f.water_level_mm = 12'd300;
        f.drawdown_rate = -16'sd1000;
        f.humidity_tenths = 10'd500;
        f.battery_mv = 13'd5000;
        return f;
    endfunction

    // Mostly close to a threshold, now and then anywhere in the field.
    function automatic int unsigned pick_near(int unsigned centre, int unsigned span,
                                              int unsigned width);
        int v;
        int top;
        top = (1 << width) - 1;
        if ($urandom_range(0, 3) == 0)
            return $urandom & unsigned'(top);
        v = int'(centre) + int'($urandom_range(0, 2 * span)) - int'(span);
        if (v < 0)
            v = 0;
        if (v > top)
            v = top;
        return unsigned'(v);
    endfunction

    function automatic logic signed [15:0] pick_rate(int centre);
        case ($urandom_range(0, 3))
            0: return 16'($urandom);
            1: return 16'(centre + int'($urandom_range(0, 16)) - 8);
            2: return 16'(-120 + int'($urandom_range(0, 16)) - 8);
            default: return 16'(int'($urandom_range(0, 1200)) - 900);
        endcase
    endfunction

    function automatic spfc_pkg::frame_t random_frame();
        spfc_pkg::frame_t f;
        int unsigned level_centre;
        case ($urandom_range(0, 4))
            0: level_centre = 32'(lim_high_water);
            1: level_centre = 32'(lim_dry_pit);
            2: level_centre = 280;
            3: level_centre = 420;
            default: level_centre = 580;
        endcase
        f.pump_current_ma = 15'(pick_near(32'(lim_run_current), 40, 15));
        f.vibration_mg = 14'(pick_near(32'(lim_run_vibration), 20, 14));
        f.water_level_mm = 12'(pick_near(level_centre, 12, 12));
        f.rebound_mm = 12'(pick_near(32'($urandom_range(0, 1) ? lim_strong_rebound
                                                              : lim_shallow_rebound), 10, 12));
        f.drawdown_rate = pick_rate(-400);
        if ($urandom_range(0, 3) == 0)
            f.rise_rate = 16'($urandom);
        else
            f.rise_rate = 16'(int'($urandom_range(0, 80)) - 20);
        f.humidity_tenths = 10'(pick_near(32'(lim_humidity), 30, 10));
        f.battery_mv = 13'(pick_near(32'(lim_low_battery), 30, 13));
        f.leak_flag = ($urandom_range(0, 7) == 0);
        f.power_fail_flag = ($urandom_range(0, 2) == 0);
        f.float_flag = 1'($urandom_range(0, 1));
        return f;
    endfunction

    // Gaps come in runs: some runs send back to back, the others mix short and long gaps.
    function automatic int unsigned next_gap();
        int unsigned r;
        if (run_left == 0)
        begin
            steady = ($urandom_range(0, 3) == 0);
            run_left = $urandom_range(20, 120);
        end
        run_left--;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(6, 40);
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
            start <= 1'b0;
        else if (!start || !busy)
        begin
            if (gap_left != 0)
            begin
                gap_left--;
                start <= 1'b0;
            end
            else if (frames_pending.size() != 0)
            begin
                start <= 1'b1;
                frame <= frames_pending.pop_front();
                gap_left = next_gap();
            end
            else
                start <= 1'b0;
        end
    end

    always @(posedge clk)
    begin : score
        spfc_pkg::result_t want;
        if (rst_n)
        begin
            if (done)
            begin
                if (results_due.size() == 0)
                begin
                    $error("result %p arrived with no frame outstanding", result);
                    fails++;
                end
                else
                begin
                    want = results_due.pop_front();
                    if (result.condition !== want.condition)
                    begin
                        $error("condition: expected %0d, got %0d", want.condition,
                               result.condition);
                        fails++;
                    end
                    if (result.flood_risk !== want.flood_risk)
                    begin
                        $error("flood_risk: expected %0d, got %0d", want.flood_risk,
                               result.flood_risk);
                        fails++;
                    end
                    if (result.cycle_health !== want.cycle_health)
                    begin
                        $error("cycle_health: expected %0d, got %0d", want.cycle_health,
                               result.cycle_health);
                        fails++;
                    end
                    if (result.severity !== want.severity)
                    begin
                        $error("severity: expected %0d, got %0d", want.severity,
                               result.severity);
                        fails++;
                    end
                end
            end
            if (start && !busy)
                results_due.push_back(classify_frame(frame));
            if (cfg_we)
            begin
                case (cfg_index)
                    spfc_pkg::REG_HIGH_WATER:      lim_high_water = cfg_data[11:0];
                    spfc_pkg::REG_DRY_PIT:         lim_dry_pit = cfg_data[11:0];
                    spfc_pkg::REG_STRONG_REBOUND:  lim_strong_rebound = cfg_data[11:0];
                    spfc_pkg::REG_SHALLOW_REBOUND: lim_shallow_rebound = cfg_data[11:0];
                    spfc_pkg::REG_HUMIDITY_ALERT:  lim_humidity = cfg_data[9:0];
                    spfc_pkg::REG_RUN_CURRENT:     lim_run_current = cfg_data[14:0];
                    spfc_pkg::REG_RUN_VIBRATION:   lim_run_vibration = cfg_data[13:0];
                    spfc_pkg::REG_LOW_BATTERY:     lim_low_battery = cfg_data[12:0];
                    default: ;
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || cfg_we)
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Sampled on the falling edge so that every update of the rising edge has settled.
    task automatic wait_idle();
        do
            @(negedge clk);
        while (frames_pending.size() != 0 || start || results_due.size() != 0);
    endtask

    task automatic write_limit(logic [spfc_pkg::CFG_IDX_W-1:0] idx,
                               logic [spfc_pkg::CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
    endtask

    task automatic apply_limits(int unsigned level_limit, int unsigned dry_pit,
                                int unsigned big_rebound, int unsigned shallow,
                                int unsigned humidity, int unsigned run_current,
                                int unsigned run_vibration, int unsigned low_battery);
        wait_idle();
        write_limit(spfc_pkg::REG_HIGH_WATER, 15'(level_limit));
        write_limit(spfc_pkg::REG_DRY_PIT, 15'(dry_pit));
        write_limit(spfc_pkg::REG_STRONG_REBOUND, 15'(big_rebound));
        write_limit(spfc_pkg::REG_SHALLOW_REBOUND, 15'(shallow));
        write_limit(spfc_pkg::REG_HUMIDITY_ALERT, 15'(humidity));
        write_limit(spfc_pkg::REG_RUN_CURRENT, 15'(run_current));
        write_limit(spfc_pkg::REG_RUN_VIBRATION, 15'(run_vibration));
        write_limit(spfc_pkg::REG_LOW_BATTERY, 15'(low_battery));
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic send_random(int unsigned count);
        repeat (count) frames_pending.push_back(random_frame());
    endtask

    initial
    begin
        spfc_pkg::frame_t f;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed frames under the reset thresholds.
        frames_pending.push_back(base_frame());
        frames_pending.push_back('0);
        frames_pending.push_back('1);
        f = base_frame(); f.leak_flag = 1'b1; f.power_fail_flag = 1'b1; f.battery_mv = 13'd0;
        frames_pending.push_back(f);
        f = base_frame(); f.float_flag = 1'b1; f.water_level_mm = 12'd501;
        frames_pending.push_back(f);
        f.water_level_mm = 12'd500;
        frames_pending.push_back(f);
        f = base_frame(); f.water_level_mm = 12'd100; f.pump_current_ma = 15'd1001;
        f.drawdown_rate = -16'sd119;
        frames_pending.push_back(f);
        f.drawdown_rate = -16'sd120;
        frames_pending.push_back(f);
        f = base_frame(); f.rebound_mm = 12'd71;
        frames_pending.push_back(f);
        f.rebound_mm = 12'd70; f.float_flag = 1'b1; f.pump_current_ma = 15'd2000;
        frames_pending.push_back(f);
        f = base_frame(); f.rebound_mm = 12'd41;
        frames_pending.push_back(f);
        f = base_frame(); f.vibration_mg = 14'd81; f.drawdown_rate = -16'sd399;
        f.water_level_mm = 12'd421;
        frames_pending.push_back(f);
        f.drawdown_rate = -16'sd400;
        frames_pending.push_back(f);
        f.drawdown_rate = 16'sd0; f.water_level_mm = 12'd420;
        frames_pending.push_back(f);
        f = base_frame(); f.humidity_tenths = 10'd821; f.rise_rate = 16'sd19;
        frames_pending.push_back(f);
        f.rise_rate = 16'sd20;
        frames_pending.push_back(f);
        f.rise_rate = 16'sd0; f.humidity_tenths = 10'd820;
        frames_pending.push_back(f);
        f.humidity_tenths = 10'd1023;
        frames_pending.push_back(f);
        f = base_frame(); f.water_level_mm = 12'd280;
        frames_pending.push_back(f);
        f.water_level_mm = 12'd281;
        frames_pending.push_back(f);
        f.water_level_mm = 12'd579;
        frames_pending.push_back(f);
        f.water_level_mm = 12'd580;
        frames_pending.push_back(f);
        f = base_frame(); f.power_fail_flag = 1'b1; f.battery_mv = 13'd3849;
        frames_pending.push_back(f);
        f.battery_mv = 13'd3850;
        frames_pending.push_back(f);
        f = base_frame(); f.drawdown_rate = 16'sh8000; f.rise_rate = 16'sh7fff;
        f.pump_current_ma = 15'd1000; f.vibration_mg = 14'd80;
        frames_pending.push_back(f);
        f.drawdown_rate = 16'sh7fff; f.rise_rate = 16'sh8000; f.humidity_tenths = 10'd900;
        frames_pending.push_back(f);
        send_random(RANDOM_PER_PHASE);

        apply_limits(0, 0, 0, 0, 0, 0, 0, 0);
        send_random(RANDOM_PER_PHASE);
        apply_limits(4095, 4095, 4095, 4095, 1023, 32767, 16383, 8191);
        send_random(RANDOM_PER_PHASE);
        apply_limits($urandom_range(0, 4095), $urandom_range(0, 4095),
                     $urandom_range(0, 4095), $urandom_range(0, 4095),
                     $urandom_range(0, 1000), $urandom_range(0, 20000),
                     $urandom_range(0, 16000), $urandom_range(0, 8191));
        send_random(RANDOM_PER_PHASE);
        // Write data wider than the register: only the low bits should be kept.
        apply_limits($urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom, $urandom, $urandom);
        send_random(RANDOM_PER_PHASE);
        apply_limits(500, 140, 70, 40, 820, 1000, 80, 3850);
        send_random(RANDOM_PER_PHASE);

        wait_idle();
        repeat (8) @(posedge clk);
        if (fails == 0 && results_due.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
